>>> src/fsps_pkg.sv
// Shared types and constants for the fair-share priority scheduler.
package fsps_pkg;

	localparam int SLOTS_DEF = 16;
	localparam logic [15:0] TSLICE_RST = 16'd10;

	localparam logic [1:0] ACT_ADMIT = 2'd0;
	localparam logic [1:0] ACT_PICK = 2'd1;
	localparam logic [1:0] ACT_CHARGE = 2'd2;
	localparam logic [1:0] ACT_FIXUP = 2'd3;

	typedef struct packed {
		logic        valid;
		logic        bio;
		logic [3:0]  group;
		logic [6:0]  base;
		logic [31:0] cpu;
		logic [31:0] gu;
		logic [31:0] pri;
		logic [31:0] rt;
	} entry_t;

endpackage

>>> src/fsps_sat_add.sv
// Shared 32-bit saturating adder.
module fsps_sat_add (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] sum
);
	logic [32:0] raw;

	assign raw = {1'b0, a} + {1'b0, b};
	assign sum = raw[32] ? 32'hFFFF_FFFF : raw[31:0];
endmodule

>>> src/fsps_table.sv
// Job entry table: one read index, one write index.
module fsps_table #(
	parameter int JOB_SLOTS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [$clog2(JOB_SLOTS)-1:0] rd_idx,
	output fsps_pkg::entry_t             rd_entry,
	input  logic                         wr_en,
	input  logic [$clog2(JOB_SLOTS)-1:0] wr_idx,
	input  fsps_pkg::entry_t             wr_entry
);
	import fsps_pkg::*;

	logic        valid_q [JOB_SLOTS];
	logic        bio_q   [JOB_SLOTS];
	logic [3:0]  group_q [JOB_SLOTS];
	logic [6:0]  base_q  [JOB_SLOTS];
	logic [31:0] cpu_q   [JOB_SLOTS];
	logic [31:0] gu_q    [JOB_SLOTS];
	logic [31:0] pri_q   [JOB_SLOTS];
	logic [31:0] rt_q    [JOB_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOB_SLOTS; i++) begin
				valid_q[i] <= 1'b0;
				bio_q[i]   <= 1'b0;
			end
		end else if (wr_en) begin
			valid_q[wr_idx] <= wr_entry.valid;
			bio_q[wr_idx]   <= wr_entry.bio;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			group_q[wr_idx] <= wr_entry.group;
			base_q[wr_idx]  <= wr_entry.base;
			cpu_q[wr_idx]   <= wr_entry.cpu;
			gu_q[wr_idx]    <= wr_entry.gu;
			pri_q[wr_idx]   <= wr_entry.pri;
			rt_q[wr_idx]    <= wr_entry.rt;
		end
	end

	always_comb begin
		rd_entry.valid = valid_q[rd_idx];
		rd_entry.bio   = bio_q[rd_idx];
		rd_entry.group = group_q[rd_idx];
		rd_entry.base  = base_q[rd_idx];
		rd_entry.cpu   = cpu_q[rd_idx];
		rd_entry.gu    = gu_q[rd_idx];
		rd_entry.pri   = pri_q[rd_idx];
		rd_entry.rt    = rt_q[rd_idx];
	end
endmodule

>>> src/fair_share_priority_scheduler.sv
// Fair-share priority scheduler top level: sequencer over the entry table.
// Admit, pick, charge and I/O fixup each walk the table; one word in flight.
// The result sits in an output register, so a new word is taken while it waits.
// Reset (arst_n low, async) clears valid and I/O marks, time_slice becomes 10;
// no clearing pass.
module fair_share_priority_scheduler #(
	parameter int JOB_SLOTS = fsps_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [3:0]  slot,
	input  logic [3:0]  group_id,
	input  logic [6:0]  base_priority,
	input  logic [31:0] time_value,
	input  logic [31:0] decision_time,
	input  logic [15:0] run_time,
	input  logic [15:0] io_time,
	input  logic        more_bursts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  chosen_slot,
	output logic        found,
	output logic [31:0] earliest_ready,
	output logic        any_valid,
	output logic [15:0] time_used,
	output logic        burst_ended,
	output logic        job_removed,
	output logic [31:0] new_time
);
	import fsps_pkg::*;

	localparam int IW = $clog2(JOB_SLOTS);
	localparam logic [IW-1:0] LAST = IW'(JOB_SLOTS - 1);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_ADMIT = 13'b0000000000010,
		S_FETCH = 13'b0000000000100,
		S_GUPD  = 13'b0000000001000,
		S_SLOT  = 13'b0000000010000,
		S_MASK  = 13'b0000000100000,
		S_COUNT = 13'b0000001000000,
		S_RCA   = 13'b0000010000000,
		S_RCB   = 13'b0000100000000,
		S_FXO   = 13'b0001000000000,
		S_FXI   = 13'b0010000000000,
		S_SCAN  = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t state_q;
	logic [15:0] tslice_q;

	logic [1:0]  act_q;
	logic [3:0]  slot_q;
	logic [3:0]  gid_q;
	logic [6:0]  base_q;
	logic [31:0] now_q;
	logic [31:0] when_q;
	logic [15:0] run_q;
	logic [15:0] io_q;
	logic        more_q;

	logic [IW-1:0] cnt_q;
	logic [IW-1:0] j_q;
	logic [3:0]    g_q;
	logic [31:0]   exec_q;
	logic          done_q;
	logic [31:0]   ntime_q;
	logic [15:0]   mask_q;
	logic [4:0]    groups_q;
	logic [35:0]   prod_q;
	logic          hit_q;
	entry_t        cur_q;

	logic [31:0] best_q;
	logic [3:0]  chosen_q;
	logic        found_q;
	logic [31:0] earl_q;
	logic        any_q;
	logic [15:0] used_q;
	logic        ended_q;
	logic        removed_q;

	logic [IW-1:0] rd_idx;
	logic [IW-1:0] wr_idx;
	logic [IW-1:0] slot_idx;
	logic [IW-1:0] cnt_nxt;
	entry_t        rd_e;
	entry_t        wr_e;
	logic          wr_en;
	logic [31:0]   alu_a;
	logic [31:0]   alu_b;
	logic [31:0]   alu_y;
	logic          slot_ok;
	logic          fx_match;
	logic [36:0]   psum;
	logic [15:0]   exec_c;
	logic          done_c;

	assign slot_idx = IW'(slot_q);
	assign slot_ok  = ({3'b0, slot_q} < 7'(JOB_SLOTS));
	assign done_c   = (run_q <= tslice_q);
	assign exec_c   = done_c ? run_q : tslice_q;
	assign fx_match = rd_e.valid && (rd_e.group == cur_q.group) && !rd_e.bio;
	assign psum     = 37'(rd_e.base) + 37'(rd_e.cpu[31:1]) + 37'(prod_q[35:2]);
	// walk index wraps at the last slot
	assign cnt_nxt  = (cnt_q == LAST) ? '0 : cnt_q + 1'b1;

	fsps_table #(.JOB_SLOTS(JOB_SLOTS)) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (rd_idx),
		.rd_entry(rd_e),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_entry(wr_e)
	);

	fsps_sat_add u_add (
		.a  (alu_a),
		.b  (alu_b),
		.sum(alu_y)
	);

	always_comb begin
		rd_idx = cnt_q;
		alu_a  = rd_e.gu;
		alu_b  = exec_q;
		case (state_q)
			S_FETCH: begin
				rd_idx = slot_idx;
				alu_a  = now_q;
				alu_b  = 32'(exec_c);
			end
			S_SLOT: begin
				rd_idx = slot_idx;
				alu_a  = done_q ? ntime_q : rd_e.cpu;
				alu_b  = done_q ? 32'(io_q) : exec_q;
			end
			S_FXI: rd_idx = j_q;
			default: ;
		endcase
	end

	always_comb begin
		wr_en  = 1'b0;
		wr_idx = cnt_q;
		wr_e   = rd_e;
		case (state_q)
			S_ADMIT: begin
				wr_en    = slot_ok;
				wr_idx   = slot_idx;
				wr_e.valid = 1'b1;
				wr_e.bio   = 1'b0;
				wr_e.group = gid_q;
				wr_e.base  = base_q;
				wr_e.cpu   = '0;
				wr_e.gu    = '0;
				wr_e.pri   = 32'(base_q);
				wr_e.rt    = now_q;
			end
			S_GUPD: begin
				wr_en   = rd_e.valid && (rd_e.group == g_q) && (rd_e.rt <= now_q);
				wr_e.gu = alu_y;
			end
			S_SLOT: begin
				wr_en  = 1'b1;
				wr_idx = slot_idx;
				if (done_q && !more_q) begin
					wr_e.valid = 1'b0;
					wr_e.bio   = 1'b0;
				end else if (done_q) begin
					wr_e.rt  = alu_y;
					wr_e.pri = 32'(rd_e.base);
					wr_e.cpu = '0;
					wr_e.gu  = '0;
					wr_e.bio = 1'b1;
				end else begin
					wr_e.cpu = alu_y;
				end
			end
			S_RCA: begin
				wr_en   = rd_e.valid && (rd_e.rt <= when_q);
				wr_e.cpu = {1'b0, rd_e.cpu[31:1]};
				wr_e.gu  = {1'b0, rd_e.gu[31:1]};
			end
			S_RCB: begin
				wr_en    = hit_q;
				wr_e.pri = (|psum[36:32]) ? 32'hFFFF_FFFF : psum[31:0];
			end
			S_FXI: begin
				wr_en   = fx_match || (j_q == LAST);
				wr_e    = cur_q;
				wr_e.bio = 1'b0;
				wr_e.gu = fx_match ? rd_e.gu : '0;
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tslice_q  <= TSLICE_RST;
			out_valid <= 1'b0;
			cnt_q     <= '0;
			j_q       <= '0;
		end else begin
			if (cfg_we)
				tslice_q <= cfg_data;
			if (out_valid && out_ready && (state_q != S_DONE))
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						case (action)
							ACT_ADMIT:  state_q <= S_ADMIT;
							ACT_PICK:   state_q <= S_SCAN;
							ACT_CHARGE: state_q <= S_FETCH;
							default:    state_q <= S_FXO;
						endcase
					end
				end
				S_ADMIT: state_q <= S_SCAN;
				S_FETCH: state_q <= (slot_ok && rd_e.valid) ? S_GUPD : S_SCAN;
				S_GUPD: begin
					cnt_q <= cnt_nxt;
					if (cnt_q == LAST)
						state_q <= S_SLOT;
				end
				S_SLOT: state_q <= S_MASK;
				S_MASK: begin
					cnt_q <= cnt_nxt;
					if (cnt_q == LAST)
						state_q <= S_COUNT;
				end
				S_COUNT: state_q <= S_RCA;
				S_RCA: state_q <= S_RCB;
				S_RCB: begin
					cnt_q   <= cnt_nxt;
					state_q <= (cnt_q == LAST) ? S_SCAN : S_RCA;
				end
				S_FXO: begin
					j_q <= '0;
					if (rd_e.valid && rd_e.bio && (rd_e.rt <= now_q)) begin
						state_q <= S_FXI;
					end else begin
						cnt_q <= cnt_nxt;
						if (cnt_q == LAST)
							state_q <= S_SCAN;
					end
				end
				S_FXI: begin
					j_q <= j_q + 1'b1;
					if (wr_en) begin
						cnt_q   <= cnt_nxt;
						state_q <= (cnt_q == LAST) ? S_SCAN : S_FXO;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_nxt;
					if (cnt_q == LAST)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q     <= action;
				slot_q    <= slot;
				gid_q     <= group_id;
				base_q    <= base_priority;
				now_q     <= time_value;
				when_q    <= decision_time;
				run_q     <= run_time;
				io_q      <= io_time;
				more_q    <= more_bursts;
				found_q   <= 1'b0;
				chosen_q  <= '0;
				best_q    <= '0;
				any_q     <= 1'b0;
				earl_q    <= '0;
				used_q    <= '0;
				ended_q   <= 1'b0;
				removed_q <= 1'b0;
				ntime_q   <= '0;
			end
			S_FETCH: begin
				if (slot_ok && rd_e.valid) begin
					g_q       <= rd_e.group;
					exec_q    <= 32'(exec_c);
					done_q    <= done_c;
					ntime_q   <= alu_y;
					used_q    <= exec_c;
					ended_q   <= done_c;
					removed_q <= done_c && !more_q;
				end
				mask_q <= '0;
			end
			S_MASK: begin
				if (rd_e.valid && (rd_e.rt <= when_q))
					mask_q[rd_e.group] <= 1'b1;
			end
			S_COUNT: groups_q <= 5'($countones(mask_q));
			S_RCA: begin
				hit_q  <= rd_e.valid && (rd_e.rt <= when_q);
				prod_q <= 36'(rd_e.gu[31:1]) * 36'(groups_q);
			end
			S_FXO: cur_q <= rd_e;
			S_SCAN: begin
				if (rd_e.valid && (!any_q || (rd_e.rt < earl_q))) begin
					earl_q <= rd_e.rt;
					any_q  <= 1'b1;
				end
				if ((act_q == ACT_PICK) && rd_e.valid && (rd_e.rt <= now_q)
						&& (!found_q || (rd_e.pri < best_q))) begin
					best_q   <= rd_e.pri;
					chosen_q <= 4'(cnt_q);
					found_q  <= 1'b1;
				end
			end
			S_DONE: begin
				if (!out_valid || out_ready) begin
					chosen_slot    <= chosen_q;
					found          <= found_q;
					earliest_ready <= earl_q;
					any_valid      <= any_q;
					time_used      <= used_q;
					burst_ended    <= ended_q;
					job_removed    <= removed_q;
					new_time       <= ntime_q;
				end
			end
			default: ;
		endcase
	end

	a_removed_ended: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && job_removed |-> burst_ended)
		else $error("job removed without burst end");

	a_used_capped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(cfg_we) && !cfg_we |-> time_used <= tslice_q)
		else $error("charged time above slice");

	a_found_any: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> any_valid)
		else $error("pick found with empty table");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");
endmodule

>>> tb/sv/fsps_checker.sv
// Watches the scheduler channels, predicts each result word and compares.
`timescale 1ns / 100ps
module fsps_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  action,
	input  logic [3:0]  slot,
	input  logic [3:0]  group_id,
	input  logic [6:0]  base_priority,
	input  logic [31:0] time_value,
	input  logic [31:0] decision_time,
	input  logic [15:0] run_time,
	input  logic [15:0] io_time,
	input  logic        more_bursts,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  chosen_slot,
	input  logic        found,
	input  logic [31:0] earliest_ready,
	input  logic        any_valid,
	input  logic [15:0] time_used,
	input  logic        burst_ended,
	input  logic        job_removed,
	input  logic [31:0] new_time,
	output int          fail_count,
	output int          pending
);
	import fsps_pkg::*;

	typedef struct packed {
		logic [3:0]  chosen;
		logic        fnd;
		logic [31:0] earliest;
		logic        any;
		logic [15:0] used;
		logic        ended;
		logic        removed;
		logic [31:0] ntime;
	} sched_result_t;

	entry_t        jobs [16];
	logic [15:0]   slice;
	sched_result_t result_q [$];

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [32:0] b);
		logic [33:0] s;
		s = 34'(a) + 34'(b);
		return (s > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic ready_at(int i, logic [31:0] t);
		return jobs[i].valid && jobs[i].rt <= t;
	endfunction

	task automatic rebalance(logic [31:0] t);
		logic [15:0] mask;
		int groups;
		logic [63:0] p;
		mask = '0;
		groups = 0;
		for (int i = 0; i < 16; i++)
			if (ready_at(i, t)) mask[jobs[i].group] = 1'b1;
		for (int i = 0; i < 16; i++) groups += int'(mask[i]);
		for (int i = 0; i < 16; i++) begin
			if (ready_at(i, t)) begin
				jobs[i].cpu = jobs[i].cpu >> 1;
				jobs[i].gu = jobs[i].gu >> 1;
				p = 64'(jobs[i].base) + 64'(jobs[i].cpu >> 1)
					+ ((64'(jobs[i].gu) * 64'(groups)) >> 2);
				jobs[i].pri = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
			end
		end
	endtask

	task automatic schedule_word();
		sched_result_t r;
		logic [31:0] best;
		logic [15:0] exec;
		logic [3:0] g;
		r = '0;
		best = '0;
		case (action)
			ACT_ADMIT: begin
				jobs[slot] = '{valid: 1'b1, bio: 1'b0, group: group_id, base: base_priority,
					cpu: 32'd0, gu: 32'd0, pri: 32'(base_priority), rt: time_value};
			end
			ACT_PICK: begin
				for (int i = 0; i < 16; i++)
					if (ready_at(i, time_value) && (!r.fnd || jobs[i].pri < best)) begin
						best = jobs[i].pri;
						r.chosen = 4'(i);
						r.fnd = 1'b1;
					end
			end
			ACT_CHARGE: begin
				if (jobs[slot].valid) begin
					g = jobs[slot].group;
					exec = (run_time <= slice) ? run_time : slice;
					for (int i = 0; i < 16; i++)
						if (ready_at(i, time_value) && jobs[i].group == g)
							jobs[i].gu = sat_add(jobs[i].gu, 33'(exec));
					r.ntime = sat_add(time_value, 33'(exec));
					r.used = exec;
					if (run_time <= slice) begin
						r.ended = 1'b1;
						if (!more_bursts) begin
							jobs[slot].valid = 1'b0;
							jobs[slot].bio = 1'b0;
							r.removed = 1'b1;
						end else begin
							jobs[slot].rt = sat_add(r.ntime, 33'(io_time));
							jobs[slot].pri = 32'(jobs[slot].base);
							jobs[slot].cpu = '0;
							jobs[slot].gu = '0;
							jobs[slot].bio = 1'b1;
						end
					end else begin
						jobs[slot].cpu = sat_add(jobs[slot].cpu, 33'(exec));
					end
					rebalance(decision_time);
				end
			end
			default: begin
				for (int i = 0; i < 16; i++) begin
					if (ready_at(i, time_value) && jobs[i].bio) begin
						jobs[i].gu = '0;
						for (int j = 0; j < 16; j++)
							if (jobs[j].valid && jobs[j].group == jobs[i].group && !jobs[j].bio) begin
								jobs[i].gu = jobs[j].gu;
								break;
							end
						jobs[i].bio = 1'b0;
					end
				end
			end
		endcase
		for (int i = 0; i < 16; i++)
			if (jobs[i].valid && (!r.any || jobs[i].rt < r.earliest)) begin
				r.earliest = jobs[i].rt;
				r.any = 1'b1;
			end
		result_q.push_back(r);
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sched_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) jobs[i] = '0;
			slice = TSLICE_RST;
			result_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) slice = cfg_data;
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$error("result word with nothing expected");
					fail_count++;
				end else begin
					e = result_q.pop_front();
					check_field("chosen_slot", 32'(e.chosen), 32'(chosen_slot));
					check_field("found", 32'(e.fnd), 32'(found));
					check_field("earliest_ready", e.earliest, earliest_ready);
					check_field("any_valid", 32'(e.any), 32'(any_valid));
					check_field("time_used", 32'(e.used), 32'(time_used));
					check_field("burst_ended", 32'(e.ended), 32'(burst_ended));
					check_field("job_removed", 32'(e.removed), 32'(job_removed));
					check_field("new_time", e.ntime, new_time);
				end
			end
			if (in_valid && in_ready) schedule_word();
		end
		pending = result_q.size();
	end
endmodule

>>> tb/sv/tb_top.sv
// Stimulus and verdict for the fair-share priority scheduler.
`timescale 1ns / 100ps
module tb_top;
	import fsps_pkg::*;

	logic clk, arst_n, cfg_we, in_valid, in_ready, out_valid, out_ready;
	logic [15:0] cfg_data;
	logic [1:0] action;
	logic [3:0] slot, group_id, chosen_slot;
	logic [6:0] base_priority;
	logic [31:0] time_value, decision_time, earliest_ready, new_time;
	logic [15:0] run_time, io_time, time_used;
	logic more_bursts, found, any_valid, burst_ended, job_removed;
	int fail_count, pending, quiet, busy_pct;
	logic [31:0] clock_now;

	fair_share_priority_scheduler uut (.*);
	fsps_checker chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// sink side stalls at random, except during the second random phase
	always @(posedge clk) out_ready <= ($urandom_range(99) >= busy_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// valid stays up between back-to-back words; it drops only while idling
	task automatic send(logic [1:0] a, logic [3:0] s, logic [3:0] g, logic [6:0] b,
		logic [31:0] tv, logic [31:0] dt, logic [15:0] rt, logic [15:0] io, logic mb);
		while ($urandom_range(99) < busy_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		action <= a; slot <= s; group_id <= g; base_priority <= b;
		time_value <= tv; decision_time <= dt; run_time <= rt; io_time <= io;
		more_bursts <= mb; in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_slice(logic [15:0] v);
		cfg_we <= 1'b1; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_word();
		logic [1:0] a;
		logic [31:0] tv;
		a = 2'($urandom_range(3));
		tv = ($urandom_range(19) == 0) ? $urandom : clock_now + $urandom_range(40);
		if ($urandom_range(3) != 0) clock_now = clock_now + $urandom_range(12);
		send(a, 4'($urandom),
			($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(3)),
			7'($urandom), tv,
			($urandom_range(7) == 0) ? $urandom : clock_now - $urandom_range(5),
			($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(30)),
			($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(20)),
			1'($urandom));
	endtask

	initial begin
		arst_n = 0; cfg_we = 0; cfg_data = 0; in_valid = 0; out_ready = 0;
		action = ACT_ADMIT; slot = 0; group_id = 0; base_priority = 0;
		time_value = 0; decision_time = 0; run_time = 0; io_time = 0; more_bursts = 0;
		busy_pct = 29; clock_now = 100;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty table, extremes, every action
		send(ACT_PICK, 0, 0, 0, 0, 0, 0, 0, 0);
		send(ACT_CHARGE, 3, 0, 0, 5, 0, 4, 0, 0);
		send(ACT_FIXUP, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
		send(ACT_ADMIT, 0, 0, 0, 0, 0, 0, 0, 0);
		send(ACT_ADMIT, 15, 15, 127, 32'hFFFF_FFF0, 0, 0, 0, 0);
		send(ACT_ADMIT, 1, 0, 3, 0, 0, 0, 0, 0);
		send(ACT_ADMIT, 2, 5, 3, 0, 0, 0, 0, 0);
		send(ACT_PICK, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
		send(ACT_CHARGE, 15, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1);
		send(ACT_CHARGE, 1, 0, 0, 0, 0, 10, 16'hFFFF, 1);
		send(ACT_CHARGE, 0, 0, 0, 1, 0, 30, 0, 1);
		send(ACT_FIXUP, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
		send(ACT_CHARGE, 2, 0, 0, 2, 2, 3, 0, 0);
		send(ACT_PICK, 0, 0, 0, 1, 0, 0, 0, 0);
		drain();
		set_slice(0);
		send(ACT_CHARGE, 0, 0, 0, 10, 10, 5, 0, 1);
		send(ACT_CHARGE, 0, 0, 0, 10, 10, 0, 0, 0);
		drain();
		set_slice(16'hFFFF);
		send(ACT_ADMIT, 4, 2, 9, 10, 0, 0, 0, 0);
		send(ACT_CHARGE, 4, 0, 0, 11, 11, 16'hFFFF, 0, 1);
		drain();
		// random phases with different slices; second phase never idles
		for (int ph = 0; ph < 4; ph++) begin
			set_slice(ph == 0 ? 16'd1 : ph == 1 ? 16'd10 :
				ph == 2 ? 16'($urandom_range(2, 40)) : 16'hFFFF);
			busy_pct = (ph == 1) ? 0 : 29;
			for (int n = 0; n < 135; n++) random_word();
			drain();
		end
		if (fail_count == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
